// ===== src/cscv_pkg.sv =====
// Shared types and constants for the color space converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package cscv_pkg;

  // channel width, 65536 means full scale
  localparam int CH_W = 17;
  localparam int FRAC_W = 16;
  localparam logic [CH_W-1:0] FULL_SCALE = 17'h10000;

  // registers from the first stage register to the last compute stage
  localparam int PIPE_LAT = 6;

  typedef enum logic [1:0] {
    SPACE_GRAY = 2'd0,
    SPACE_RGB  = 2'd1,
    SPACE_CMYK = 2'd2
  } space_t;

endpackage

`default_nettype wire

// ===== src/color_space_converter.sv =====
// Color space converter top level: input register, blend and gray pipelines,
// output select. Depends on cscv_pkg, cscv_blend and cscv_gray.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input: drive in_channel_0..3 and raise start; a color transfers at every
//   rising edge with start high and busy low. busy is high during reset and
//   until the first edge after it, so one color can be taken in every cycle
//   after that. Channels above 65536 are saturated to 65536.
//   Config: cfg_data selects the source space (0 gray, 1 RGB, 2 CMYK; 3 acts
//   as gray). It transfers when cfg_valid and cfg_ready are high; write it
//   only while no color is in flight. The space is sampled with each color.
//   Output: out_strobe is high for one cycle with all eight results on the
//   out_ ports, after the input register, the pipelines and the output register.
//   Throughput: one color per cycle; every stage is fully pipelined, the
//   CMYK blend uses three chained weight multiplier stages and one 48-product
//   stage, and the gray divide by 100 is a split reciprocal multiply.
//   Reset: synchronous, clears the source space to gray and drops all strobes.
//   The receiver cannot hold results off; nothing in the block ever stalls.
module color_space_converter (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [cscv_pkg::CH_W-1:0] in_channel_0,
  input  logic [cscv_pkg::CH_W-1:0] in_channel_1,
  input  logic [cscv_pkg::CH_W-1:0] in_channel_2,
  input  logic [cscv_pkg::CH_W-1:0] in_channel_3,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_data,
  output logic                      out_strobe,
  output logic [cscv_pkg::CH_W-1:0] out_gray_out,
  output logic [cscv_pkg::CH_W-1:0] out_red_out,
  output logic [cscv_pkg::CH_W-1:0] out_green_out,
  output logic [cscv_pkg::CH_W-1:0] out_blue_out,
  output logic [cscv_pkg::CH_W-1:0] out_cyan_out,
  output logic [cscv_pkg::CH_W-1:0] out_magenta_out,
  output logic [cscv_pkg::CH_W-1:0] out_yellow_out,
  output logic [cscv_pkg::CH_W-1:0] out_black_out
);
  import cscv_pkg::*;

  logic               busy_r;
  logic [1:0]         space_r;
  logic               accept;
  logic [PIPE_LAT:0]  vld_r;
  logic [CH_W-1:0]    in_raw [4];
  logic [CH_W-1:0]    st_v_nxt [4];
  logic [CH_W-1:0]    st_v_r [4];
  logic [1:0]         st_sp_r;
  logic [CH_W-1:0]    dv_r [PIPE_LAT][4];
  logic [1:0]         dsp_r [PIPE_LAT];
  logic [CH_W-1:0]    bl_red, bl_green, bl_blue;
  logic [CH_W-1:0]    gray_q;
  logic [CH_W-1:0]    fv [4];
  logic [CH_W-1:0]    cc, mc, yc, kmin;
  logic               strobe_r;
  logic [CH_W-1:0]    gray_nxt, red_nxt, green_nxt, blue_nxt;
  logic [CH_W-1:0]    cyan_nxt, magenta_nxt, yellow_nxt, black_nxt;
  logic [CH_W-1:0]    gray_r, red_r, green_r, blue_r;
  logic [CH_W-1:0]    cyan_r, magenta_r, yellow_r, black_r;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = !busy_r;

  always_comb begin
    in_raw[0] = in_channel_0;
    in_raw[1] = in_channel_1;
    in_raw[2] = in_channel_2;
    in_raw[3] = in_channel_3;
    for (int i = 0; i < 4; i++) begin
      st_v_nxt[i] = (in_raw[i] > FULL_SCALE) ? FULL_SCALE : in_raw[i];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      space_r  <= SPACE_GRAY;
      vld_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      busy_r   <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        space_r <= cfg_data;
      end
      vld_r    <= {vld_r[PIPE_LAT-1:0], accept};
      strobe_r <= vld_r[PIPE_LAT];
    end
  end

  // payload, free running; the strobe chain marks live entries
  always_ff @(posedge clk) begin
    st_v_r   <= st_v_nxt;
    st_sp_r  <= space_r;
    dv_r[0]  <= st_v_r;
    dsp_r[0] <= st_sp_r;
    for (int k = 1; k < PIPE_LAT; k++) begin
      dv_r[k]  <= dv_r[k-1];
      dsp_r[k] <= dsp_r[k-1];
    end
  end

  cscv_blend u_blend (
    .clk     (clk),
    .cyan    (st_v_r[0]),
    .magenta (st_v_r[1]),
    .yellow  (st_v_r[2]),
    .black   (st_v_r[3]),
    .red     (bl_red),
    .green   (bl_green),
    .blue    (bl_blue)
  );

  cscv_gray u_gray (
    .clk   (clk),
    .space (st_sp_r),
    .ch0   (st_v_r[0]),
    .ch1   (st_v_r[1]),
    .ch2   (st_v_r[2]),
    .ch3   (st_v_r[3]),
    .gray  (gray_q)
  );

  // output select; RGB source extracts black as the smallest complement
  always_comb begin
    fv   = dv_r[PIPE_LAT-1];
    cc   = FULL_SCALE - fv[0];
    mc   = FULL_SCALE - fv[1];
    yc   = FULL_SCALE - fv[2];
    kmin = cc;
    if (mc < kmin) begin
      kmin = mc;
    end
    if (yc < kmin) begin
      kmin = yc;
    end
    unique case (dsp_r[PIPE_LAT-1])
      SPACE_RGB: begin
        gray_nxt    = gray_q;
        red_nxt     = fv[0];
        green_nxt   = fv[1];
        blue_nxt    = fv[2];
        cyan_nxt    = cc - kmin;
        magenta_nxt = mc - kmin;
        yellow_nxt  = yc - kmin;
        black_nxt   = kmin;
      end
      SPACE_CMYK: begin
        gray_nxt    = gray_q;
        red_nxt     = bl_red;
        green_nxt   = bl_green;
        blue_nxt    = bl_blue;
        cyan_nxt    = fv[0];
        magenta_nxt = fv[1];
        yellow_nxt  = fv[2];
        black_nxt   = fv[3];
      end
      default: begin
        gray_nxt    = fv[0];
        red_nxt     = fv[0];
        green_nxt   = fv[0];
        blue_nxt    = fv[0];
        cyan_nxt    = '0;
        magenta_nxt = '0;
        yellow_nxt  = '0;
        black_nxt   = cc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    gray_r    <= gray_nxt;
    red_r     <= red_nxt;
    green_r   <= green_nxt;
    blue_r    <= blue_nxt;
    cyan_r    <= cyan_nxt;
    magenta_r <= magenta_nxt;
    yellow_r  <= yellow_nxt;
    black_r   <= black_nxt;
  end

  assign out_strobe      = strobe_r;
  assign out_gray_out    = gray_r;
  assign out_red_out     = red_r;
  assign out_green_out   = green_r;
  assign out_blue_out    = blue_r;
  assign out_cyan_out    = cyan_r;
  assign out_magenta_out = magenta_r;
  assign out_yellow_out  = yellow_r;
  assign out_black_out   = black_r;

endmodule

`default_nettype wire

// ===== src/cscv_blend.sv =====
// Multilinear CMYK to RGB blend over 16 corner colors, six register stages.
// Depends on cscv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cscv_blend (
  input  logic                     clk,
  input  logic [cscv_pkg::CH_W-1:0] cyan,
  input  logic [cscv_pkg::CH_W-1:0] magenta,
  input  logic [cscv_pkg::CH_W-1:0] yellow,
  input  logic [cscv_pkg::CH_W-1:0] black,
  output logic [cscv_pkg::CH_W-1:0] red,
  output logic [cscv_pkg::CH_W-1:0] green,
  output logic [cscv_pkg::CH_W-1:0] blue
);
  import cscv_pkg::*;

  localparam int NUM_CORNERS = 16;
  localparam int NUM_PRIM = 3;
  localparam int PART_W = CH_W + 2;
  localparam int TOT_W = CH_W + 4;

  // corner colors {R, G, B}, index bits C M Y K with C the MSB
  localparam logic [CH_W-1:0] CORNER_RGB [NUM_CORNERS][NUM_PRIM] = '{
    '{17'd65536, 17'd65536, 17'd65536},
    '{17'd8998,  17'd7969,  17'd8225},
    '{17'd65536, 17'd62194, 17'd0},
    '{17'd7196,  17'd6685,  17'd0},
    '{17'd60654, 17'd0,     17'd35979},
    '{17'd9254,  17'd0,     17'd0},
    '{17'd60909, 17'd7196,  17'd9254},
    '{17'd8736,  17'd0,     17'd0},
    '{17'd0,     17'd44460, 17'd61427},
    '{17'd0,     17'd3854,  17'd9254},
    '{17'd0,     17'd42664, 17'd20559},
    '{17'd0,     17'd4882,  17'd0},
    '{17'd11823, 17'd12596, 17'd37519},
    '{17'd0,     17'd0,     17'd511},
    '{17'd13881, 17'd13887, 17'd14647},
    '{17'd0,     17'd0,     17'd0}
  };

  function automatic logic [CH_W-1:0] mul_q16(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b);
    logic [2*CH_W-1:0] p;
    p = a * b;
    return p[CH_W+FRAC_W-1:FRAC_W];
  endfunction

  logic [CH_W-1:0]   cf [2];
  logic [CH_W-1:0]   mf [2];
  logic [CH_W-1:0]   yf [2];
  logic [CH_W-1:0]   kf [2];
  logic [CH_W-1:0]   y1_r, k1_r, k2_r;
  logic [CH_W-1:0]   cm_nxt [4];
  logic [CH_W-1:0]   cm_r [4];
  logic [CH_W-1:0]   cmy_nxt [8];
  logic [CH_W-1:0]   cmy_r [8];
  logic [CH_W-1:0]   w_nxt [NUM_CORNERS];
  logic [CH_W-1:0]   w_r [NUM_CORNERS];
  logic [CH_W-1:0]   ctb_nxt [NUM_CORNERS][NUM_PRIM];
  logic [CH_W-1:0]   ctb_r [NUM_CORNERS][NUM_PRIM];
  logic [PART_W-1:0] part_nxt [4][NUM_PRIM];
  logic [PART_W-1:0] part_r [4][NUM_PRIM];
  logic [TOT_W-1:0]  tot [NUM_PRIM];
  logic [CH_W-1:0]   rgb_nxt [NUM_PRIM];
  logic [CH_W-1:0]   rgb_r [NUM_PRIM];

  // factor 1 is the channel, factor 0 its complement
  always_comb begin
    cf[1] = cyan;
    cf[0] = FULL_SCALE - cyan;
    mf[1] = magenta;
    mf[0] = FULL_SCALE - magenta;
    yf[1] = y1_r;
    yf[0] = FULL_SCALE - y1_r;
    kf[1] = k2_r;
    kf[0] = FULL_SCALE - k2_r;
  end

  // weights are built C, then M, then Y, then K, truncating after each step
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cm_nxt[i] = mul_q16(cf[1'(i >> 1)], mf[1'(i & 1)]);
    end
    for (int j = 0; j < 8; j++) begin
      cmy_nxt[j] = mul_q16(cm_r[2'(j >> 1)], yf[1'(j & 1)]);
    end
    for (int n = 0; n < NUM_CORNERS; n++) begin
      w_nxt[n] = mul_q16(cmy_r[3'(n >> 1)], kf[1'(n & 1)]);
    end
  end

  always_comb begin
    for (int n = 0; n < NUM_CORNERS; n++) begin
      for (int c = 0; c < NUM_PRIM; c++) begin
        ctb_nxt[n][c] = mul_q16(CORNER_RGB[n][c], w_r[n]);
      end
    end
    for (int g = 0; g < 4; g++) begin
      for (int c = 0; c < NUM_PRIM; c++) begin
        part_nxt[g][c] = PART_W'(ctb_r[4*g][c]) + PART_W'(ctb_r[4*g+1][c])
                       + PART_W'(ctb_r[4*g+2][c]) + PART_W'(ctb_r[4*g+3][c]);
      end
    end
    for (int c = 0; c < NUM_PRIM; c++) begin
      tot[c] = TOT_W'(part_r[0][c]) + TOT_W'(part_r[1][c])
             + TOT_W'(part_r[2][c]) + TOT_W'(part_r[3][c]);
      rgb_nxt[c] = (tot[c] > TOT_W'(FULL_SCALE)) ? FULL_SCALE : tot[c][CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    y1_r   <= yellow;
    k1_r   <= black;
    k2_r   <= k1_r;
    cm_r   <= cm_nxt;
    cmy_r  <= cmy_nxt;
    w_r    <= w_nxt;
    ctb_r  <= ctb_nxt;
    part_r <= part_nxt;
    rgb_r  <= rgb_nxt;
  end

  assign red   = rgb_r[0];
  assign green = rgb_r[1];
  assign blue  = rgb_r[2];

endmodule

`default_nettype wire

// ===== src/cscv_gray.sv =====
// Gray level from RGB or CMYK: weighted sum, round, divide by 100.
// Six register stages to line up with the blend. Depends on cscv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cscv_gray (
  input  logic                      clk,
  input  logic [1:0]                space,
  input  logic [cscv_pkg::CH_W-1:0] ch0,
  input  logic [cscv_pkg::CH_W-1:0] ch1,
  input  logic [cscv_pkg::CH_W-1:0] ch2,
  input  logic [cscv_pkg::CH_W-1:0] ch3,
  output logic [cscv_pkg::CH_W-1:0] gray
);
  import cscv_pkg::*;

  localparam int SUM_W = CH_W + 6;            // holds 100 * 65536 + 50
  localparam int QT_W = SUM_W - 2;            // sum / 4
  localparam int RECIP_W = 22;
  localparam int SPLIT = 11;
  localparam int PP_W = QT_W + SPLIT;
  localparam int FULL_W = QT_W + RECIP_W;
  localparam int DIV_SHIFT = 26;
  localparam int PAD = PIPE_LAT - 3;
  // floor(x / 25) = (x * RECIP_25) >> 26 for x below 2^21
  localparam logic [RECIP_W-1:0] RECIP_25 = 22'd2684355;
  localparam logic [SUM_W-1:0] WT_R = 23'd30;
  localparam logic [SUM_W-1:0] WT_G = 23'd59;
  localparam logic [SUM_W-1:0] WT_B = 23'd11;
  localparam logic [SUM_W-1:0] WT_K = 23'd100;
  localparam logic [SUM_W-1:0] ROUND_BIAS = 23'd50;

  logic [SUM_W-1:0]  wsum;
  logic [SUM_W-1:0]  pos_nxt, pos_r;
  logic [SUM_W-1:0]  neg_nxt, neg_r;
  logic [SUM_W-1:0]  diff;
  logic [QT_W-1:0]   qt_nxt, qt_r;
  logic [PP_W-1:0]   plo_nxt, plo_r;
  logic [PP_W-1:0]   phi_nxt, phi_r;
  logic [FULL_W-1:0] full;
  logic [CH_W-1:0]   gray_nxt;
  logic [CH_W-1:0]   pad_r [PAD];

  always_comb begin
    wsum = WT_R * SUM_W'(ch0) + WT_G * SUM_W'(ch1) + WT_B * SUM_W'(ch2);
    if (space == SPACE_CMYK) begin
      pos_nxt = WT_K * SUM_W'(FULL_SCALE - ch3) + ROUND_BIAS;
      neg_nxt = wsum;
    end else begin
      pos_nxt = wsum + ROUND_BIAS;
      neg_nxt = '0;
    end
  end

  // a negative CMYK sum gives black
  always_comb begin
    diff    = pos_r - neg_r;
    qt_nxt  = (pos_r >= neg_r) ? diff[SUM_W-1:2] : '0;
    plo_nxt = PP_W'(qt_r) * PP_W'(RECIP_25[SPLIT-1:0]);
    phi_nxt = PP_W'(qt_r) * PP_W'(RECIP_25[RECIP_W-1:SPLIT]);
    full    = (FULL_W'(phi_r) << SPLIT) + FULL_W'(plo_r);
    gray_nxt = full[DIV_SHIFT+CH_W-1:DIV_SHIFT];
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    neg_r <= neg_nxt;
    qt_r  <= qt_nxt;
    plo_r <= plo_nxt;
    phi_r <= phi_nxt;
    pad_r[0] <= gray_nxt;
    for (int k = 1; k < PAD; k++) begin
      pad_r[k] <= pad_r[k-1];
    end
  end

  assign gray = pad_r[PAD-1];

endmodule

`default_nettype wire
